// ----- rtl/steer_throttle_servo_mapper_unit_macros.svh -----
// Assertion macros used by the servo mapper controller RTL.
`ifndef STEER_THROTTLE_SERVO_MAPPER_UNIT_MACROS_SVH
`define STEER_THROTTLE_SERVO_MAPPER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define STSM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define STSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/stsm_pkg.sv -----
// Shared types, codes and constants of the servo mapper.
package stsm_pkg;
	localparam int TABLE_SIZE_DEF = 16;
	localparam int STEP_DEGREES   = 4;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// shared divider widths
	localparam int DIV_NUM_W = 60;
	localparam int DIV_DEN_W = 44;
	localparam int DIV_Q_W   = 32;

	// fixed-point constants (Q8.8 where a _Q position; POS_MAX in whole positions)
	localparam int CENTER_Q = 23040;
	localparam int FULL_Q   = 46080;
	localparam int THR_OFFS = 25600;
	localparam int THR_DEN  = 2560;
	localparam int POS_MAX  = 180;

	// command codes
	localparam logic [1:0] CMD_STEER    = 2'd0;
	localparam logic [1:0] CMD_SPEED    = 2'd1;
	localparam logic [1:0] CMD_THROTTLE = 2'd2;
	localparam logic [1:0] CMD_WRITE    = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STEER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FWD_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REV_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_SPEED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RPM   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM   = 3'd6;

	// datapath operations
	localparam logic [4:0] OP_NONE     = 5'd0;
	localparam logic [4:0] OP_LOAD     = 5'd1;
	localparam logic [4:0] OP_ST_PREP  = 5'd2;
	localparam logic [4:0] OP_SP_MUL1  = 5'd3;
	localparam logic [4:0] OP_SP_MUL2  = 5'd4;
	localparam logic [4:0] OP_SP_CLAMP = 5'd5;
	localparam logic [4:0] OP_SP_SCALE = 5'd6;
	localparam logic [4:0] OP_TH_PREP  = 5'd7;
	localparam logic [4:0] OP_ST_CAP   = 5'd8;
	localparam logic [4:0] OP_SP_CAP   = 5'd9;
	localparam logic [4:0] OP_IX_PREP  = 5'd10;
	localparam logic [4:0] OP_DB_RDL   = 5'd12;
	localparam logic [4:0] OP_DB_RDR   = 5'd13;
	localparam logic [4:0] OP_DB_LATR  = 5'd14;
	localparam logic [4:0] OP_DB_PREP  = 5'd15;
	localparam logic [4:0] OP_DB_ABS   = 5'd16;
	localparam logic [4:0] OP_DB_CAP   = 5'd17;
	localparam logic [4:0] OP_SP_PUSH  = 5'd18;

	typedef struct packed {
		logic [4:0] op;
		logic       div_start;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic skip;
		logic div_done;
	} dp_stat_t;
endpackage

// ----- rtl/stsm_if.sv -----
// Command and result channel interfaces of the servo mapper.
interface stsm_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic signed [15:0] value;
	logic [3:0]        table_index;
	logic [14:0]       table_steer;
	logic [14:0]       table_deadband;

	modport source(output valid, command, value, table_index, table_steer, table_deadband,
		input ready);
	modport sink(input valid, command, value, table_index, table_steer, table_deadband,
		output ready);
endinterface

interface stsm_out_if;
	logic       valid;
	logic       ready;
	logic       servo_channel;
	logic [7:0] servo_position;

	modport source(output valid, servo_channel, servo_position, input ready);
	modport sink(input valid, servo_channel, servo_position, output ready);
endinterface

// ----- rtl/steer_throttle_servo_mapper_unit.sv -----
// Top level of the steering and throttle servo mapper.
// One command beat at a time: set_steering and set_speed wait on the shared restoring
// divider (one quotient bit a cycle, 16 bits for the steering or rpm divide, 32 for the
// deadband interpolation, then the quotient is handed over); equal or inverted limits
// and equal breakpoints skip their divide. set_throttle needs no divider (its constant
// divide is a shift and a reciprocal multiply), and write_table returns no result beat.
// A finished result waits in an output register, so the next command is taken while it is
// still pending; that command's result then holds until the beat is taken.
// Table entries read as zero until written, so no clearing pass is needed after reset.
module steer_throttle_servo_mapper_unit #(
	parameter int TABLE_SIZE = stsm_pkg::TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	stsm_in_if.sink                       cmd_ch,
	stsm_out_if.source                    res_ch,
	input  logic                          cfg_we,
	input  logic [stsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [stsm_pkg::CFG_W-1:0]     cfg_data
);
	import stsm_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	stsm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd_ch.valid),
		.in_command (cmd_ch.command),
		.in_ready   (cmd_ch.ready),
		.out_ready  (res_ch.ready),
		.out_valid  (res_ch.valid),
		.cmd        (cmd),
		.stat       (stat)
	);

	stsm_datapath #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_command        (cmd_ch.command),
		.in_value          (cmd_ch.value),
		.in_table_index    (cmd_ch.table_index),
		.in_table_steer    (cmd_ch.table_steer),
		.in_table_deadband (cmd_ch.table_deadband),
		.cmd               (cmd),
		.stat              (stat),
		.out_channel       (res_ch.servo_channel),
		.out_position      (res_ch.servo_position)
	);
endmodule

// ----- rtl/stsm_div.sv -----
// Shared restoring divider, one quotient bit per cycle, 16 or 32 quotient bits.
module stsm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          wide,
	input  logic [stsm_pkg::DIV_NUM_W-1:0] num,
	input  logic [stsm_pkg::DIV_DEN_W-1:0] den,
	output logic                          done,
	output logic [stsm_pkg::DIV_Q_W-1:0]   quo
);
	import stsm_pkg::*;

	localparam int CNT_W = $clog2(DIV_Q_W);

	logic [DIV_NUM_W-1:0] rem_q, dsh_q, diff;
	logic [DIV_Q_W-1:0]   quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q, done_q, ge;

	// trial subtract of the shifted divisor
	assign ge   = rem_q >= dsh_q;
	assign diff = rem_q - dsh_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= wide ? CNT_W'(DIV_Q_W - 1) : CNT_W'(DIV_Q_W / 2 - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// remainder, divisor and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= wide ? (DIV_NUM_W'(den) << (DIV_Q_W - 1))
				: (DIV_NUM_W'(den) << (DIV_Q_W / 2 - 1));
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) rem_q <= diff;
			quo_q <= {quo_q[DIV_Q_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ----- rtl/stsm_datapath.sv -----
// Datapath: config registers, breakpoint table, arithmetic and result register.
module stsm_datapath #(
	parameter int TABLE_SIZE = stsm_pkg::TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [stsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [stsm_pkg::CFG_W-1:0]     cfg_data,
	input  logic [1:0]                    in_command,
	input  logic signed [15:0]            in_value,
	input  logic [3:0]                    in_table_index,
	input  logic [14:0]                   in_table_steer,
	input  logic [14:0]                   in_table_deadband,
	input  stsm_pkg::dp_cmd_t              cmd,
	output stsm_pkg::dp_stat_t             stat,
	output logic                          out_channel,
	output logic [7:0]                    out_position
);
	import stsm_pkg::*;

	localparam int AW = $clog2(TABLE_SIZE);
	// the breakpoint step is a power of two degrees, so the index is a shift
	localparam int IDX_SH = $clog2(STEP_DEGREES * 256);
	localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);
	// x / 5 as (x * 52429) >> 18, exact for x below 2^16
	localparam logic [15:0] THR_RECIP = 16'd52429;

	// configuration
	logic signed [7:0]  min_sa_q, max_sa_q;
	logic [15:0]        fwd_q, rev_q, rps_q;
	logic signed [15:0] min_rpm_q, max_rpm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sa_q  <= -8'sd30;
			max_sa_q  <= 8'sd30;
			fwd_q     <= 16'd4096;
			rev_q     <= 16'd4096;
			rps_q     <= 16'd20352;
			min_rpm_q <= -16'sd1000;
			max_rpm_q <= 16'sd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_STEER: min_sa_q  <= cfg_data[7:0];
				REG_MAX_STEER: max_sa_q  <= cfg_data[7:0];
				REG_FWD_GAIN:  fwd_q     <= cfg_data;
				REG_REV_GAIN:  rev_q     <= cfg_data;
				REG_RPM_SPEED: rps_q     <= cfg_data;
				REG_MIN_RPM:   min_rpm_q <= cfg_data;
				REG_MAX_RPM:   max_rpm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// working registers
	logic [1:0]            cmd_q;
	logic signed [15:0]    val_q, steer_q;
	logic [DIV_NUM_W-1:0]  num_q;
	logic [DIV_DEN_W-1:0]  den_q;
	logic                  wide_q, skip_q, neg_q;
	logic [7:0]            res_q;
	logic [15:0]           pos_q, ang_q;
	logic signed [31:0]    p1_q;
	logic signed [47:0]    rpm_q;
	logic [AW-1:0]         l_q, r_q;
	logic [14:0]           bl_q, dl_q, br_q, dr_q;
	logic signed [33:0]    prod_q;
	logic signed [15:0]    dden_q;
	logic signed [32:0]    w_q;
	logic                  out_ch_q;
	logic [7:0]            out_pos_q;

	// breakpoint table with per-entry valid bits
	logic [29:0]           tbl_mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] tvld_q;
	logic [29:0]           rd_q;
	logic                  rd_vld_q;
	logic                  wr;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic [29:0]           entry;

	assign wr      = (cmd.op == OP_LOAD) && (in_command == CMD_WRITE)
		&& (int'(in_table_index) < TABLE_SIZE);
	assign wr_addr = AW'(in_table_index);
	assign rd_addr = (cmd.op == OP_DB_RDR) ? r_q : l_q;
	assign entry   = rd_vld_q ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (wr) tbl_mem[wr_addr] <= {in_table_steer, in_table_deadband};
		rd_q <= tbl_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvld_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr) tvld_q[wr_addr] <= 1'b1;
			rd_vld_q <= tvld_q[rd_addr];
		end
	end

	// divider
	logic                 div_done;
	logic [DIV_Q_W-1:0]   div_quo;

	stsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.wide   (wide_q),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// steering: clamp and numerator
	logic signed [15:0] lo_a, hi_a, a_cl;
	logic signed [16:0] st_den;
	logic [16:0]        st_off;
	logic [23:0]        st_num;

	assign lo_a   = {min_sa_q, 8'd0};
	assign hi_a   = {max_sa_q, 8'd0};
	assign a_cl   = (val_q < lo_a) ? lo_a : ((val_q > hi_a) ? hi_a : val_q);
	assign st_den = {hi_a[15], hi_a} - {lo_a[15], lo_a};
	assign st_off = {a_cl[15], a_cl} - {lo_a[15], lo_a};
	assign st_num = ({8'd0, st_off[15:0]} << 7) + ({8'd0, st_off[15:0]} << 5)
		+ ({8'd0, st_off[15:0]} << 4) + ({8'd0, st_off[15:0]} << 2);

	// speed: gain products and rpm clamp
	logic [15:0]        gain;
	logic signed [32:0] p1_full;
	logic signed [48:0] p2_full;
	logic signed [47:0] lo_r, hi_r, r1, r2, sp_den, sp_diff;

	assign gain    = val_q[15] ? rev_q : fwd_q;
	assign p1_full = val_q * $signed({1'b0, gain});
	assign p2_full = p1_q * $signed({1'b0, rps_q});
	assign lo_r    = {{6{min_rpm_q[15]}}, min_rpm_q, 26'd0};
	assign hi_r    = {{6{max_rpm_q[15]}}, max_rpm_q, 26'd0};
	assign r1      = (rpm_q < lo_r) ? lo_r : rpm_q;
	assign r2      = (r1 > hi_r) ? hi_r : r1;
	assign sp_den  = hi_r - lo_r;
	assign sp_diff = r2 - lo_r;

	// throttle: numerator, then /2560 as >>9 and /5 by reciprocal
	logic signed [16:0] th_t;
	logic signed [20:0] th_e, th_n;
	logic [10:0]        th_x;
	logic [26:0]        th_m;
	logic [7:0]         th_res;

	assign th_t   = {val_q[15], val_q} + 17'sd25600;
	assign th_e   = {{4{th_t[16]}}, th_t};
	assign th_n   = (th_e <<< 3) + th_e;
	assign th_x   = th_n[19:9];
	assign th_m   = 27'(th_x) * 27'(THR_RECIP);
	// negative numerator truncates to zero or below, so position 0
	assign th_res = th_n[20] ? 8'd0
		: ((th_m[26:18] > 9'(POS_MAX)) ? 8'(POS_MAX) : th_m[25:18]);

	// deadband interpolation
	logic [15:0]        ang_c, ix_c;
	logic [AW-1:0]      l_c;
	logic signed [17:0] dn;
	logic signed [15:0] dd;
	logic [33:0]        prod_abs;
	logic [15:0]        dden_abs;
	logic signed [32:0] q_s, dl_ext;

	assign ang_c    = steer_q[15] ? 16'(-steer_q) : 16'(steer_q);
	assign ix_c     = ang_c >> IDX_SH;
	assign l_c      = (ix_c > 16'(TABLE_SIZE - 1)) ? LAST : AW'(ix_c);
	assign dn       = {2'b00, ang_q} - {3'b000, bl_q};
	assign dd       = {1'b0, dr_q} - {1'b0, dl_q};
	assign prod_abs = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
	assign dden_abs = dden_q[15] ? 16'(-dden_q) : 16'(dden_q);
	assign q_s      = {1'b0, div_quo};
	assign dl_ext   = {18'd0, dl_q};

	// deadband push and final truncation
	logic signed [34:0] ps, cq, w35, lw, hw, np;
	logic               in_band;
	logic [7:0]         push_res, quo_sat;

	assign ps       = {19'd0, pos_q};
	assign cq       = 35'(CENTER_Q);
	assign w35      = {{2{w_q[32]}}, w_q};
	assign lw       = cq - w35;
	assign hw       = cq + w35;
	assign in_band  = (ps != cq) && (ps > lw) && (ps < hw);
	assign np       = in_band ? ((ps < cq) ? lw : hw) : ps;
	assign push_res = np[34] ? 8'd0
		: ((np[34:8] > 27'(POS_MAX)) ? 8'(POS_MAX) : np[15:8]);
	assign quo_sat  = (div_quo > DIV_Q_W'(POS_MAX)) ? 8'(POS_MAX) : div_quo[7:0];

	// stored steering angle and skip flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_q <= '0;
			skip_q  <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_ST_PREP: begin
					steer_q <= a_cl;
					skip_q  <= st_den <= 0;
				end
				OP_SP_CLAMP: skip_q <= sp_den <= 0;
				OP_DB_PREP:  skip_q <= br_q == bl_q;
				default: ;
			endcase
		end
	end

	// operation sequencing of the working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				cmd_q <= in_command;
				val_q <= in_value;
			end
			OP_ST_PREP: begin
				num_q  <= DIV_NUM_W'(st_num);
				den_q  <= DIV_DEN_W'(st_den[15:0]);
				wide_q <= 1'b0;
				res_q  <= (st_den < 0 && !(val_q < lo_a)) ? 8'(POS_MAX) : 8'd0;
			end
			OP_SP_MUL1:  p1_q  <= p1_full[31:0];
			OP_SP_MUL2:  rpm_q <= p2_full[47:0];
			OP_SP_CLAMP: begin
				num_q  <= DIV_NUM_W'(sp_diff[41:0]);
				den_q  <= DIV_DEN_W'(sp_den[41:0]);
				wide_q <= 1'b0;
				pos_q  <= (sp_den < 0) ? 16'(FULL_Q) : 16'd0;
			end
			OP_SP_SCALE: num_q <= (num_q << 15) + (num_q << 13) + (num_q << 12) + (num_q << 10);
			OP_TH_PREP:  res_q <= th_res;
			OP_ST_CAP: if (!skip_q) res_q <= quo_sat;
			OP_SP_CAP: if (!skip_q) pos_q <= div_quo[15:0];
			OP_IX_PREP: begin
				ang_q <= ang_c;
				l_q   <= l_c;
				r_q   <= (l_c == LAST) ? l_c : l_c + AW'(1);
			end
			OP_DB_RDR: begin
				bl_q <= entry[29:15];
				dl_q <= entry[14:0];
			end
			OP_DB_LATR: begin
				br_q <= entry[29:15];
				dr_q <= entry[14:0];
			end
			OP_DB_PREP: begin
				prod_q <= dn * dd;
				dden_q <= {1'b0, br_q} - {1'b0, bl_q};
			end
			OP_DB_ABS: begin
				num_q  <= DIV_NUM_W'(prod_abs);
				den_q  <= DIV_DEN_W'(dden_abs);
				wide_q <= 1'b1;
				neg_q  <= prod_q[33] ^ dden_q[15];
			end
			OP_DB_CAP: w_q <= skip_q ? dl_ext : (neg_q ? dl_ext - q_s : dl_ext + q_s);
			OP_SP_PUSH: res_q <= push_res;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_ch_q  <= cmd_q != CMD_STEER;
			out_pos_q <= res_q;
		end
	end

	assign stat.skip     = skip_q;
	assign stat.div_done = div_done;
	assign out_channel   = out_ch_q;
	assign out_position  = out_pos_q;
endmodule

// ----- rtl/stsm_ctrl.sv -----
// Controller: command sequencing state machine and result beat handshake.
module stsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_command,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	output stsm_pkg::dp_cmd_t  cmd,
	input  stsm_pkg::dp_stat_t stat
);
	import stsm_pkg::*;
	`include "steer_throttle_servo_mapper_unit_macros.svh"

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_ST_PREP  = 5'd1;
	localparam logic [4:0] S_SP_MUL1  = 5'd2;
	localparam logic [4:0] S_SP_MUL2  = 5'd3;
	localparam logic [4:0] S_SP_CLAMP = 5'd4;
	localparam logic [4:0] S_SP_SCALE = 5'd5;
	localparam logic [4:0] S_TH_PREP  = 5'd6;
	localparam logic [4:0] S_DIV_GO   = 5'd7;
	localparam logic [4:0] S_DIV_WAIT = 5'd8;
	localparam logic [4:0] S_ST_CAP   = 5'd9;
	localparam logic [4:0] S_SP_CAP   = 5'd10;
	localparam logic [4:0] S_IX_PREP  = 5'd11;
	localparam logic [4:0] S_DB_RDL   = 5'd13;
	localparam logic [4:0] S_DB_RDR   = 5'd14;
	localparam logic [4:0] S_DB_LATR  = 5'd15;
	localparam logic [4:0] S_DB_PREP  = 5'd16;
	localparam logic [4:0] S_DB_ABS   = 5'd17;
	localparam logic [4:0] S_DB_CAP   = 5'd18;
	localparam logic [4:0] S_SP_PUSH  = 5'd19;
	localparam logic [4:0] S_FIN      = 5'd21;

	// which divide is in flight
	localparam logic [2:0] PH_ST = 3'd0;
	localparam logic [2:0] PH_SP = 3'd1;
	localparam logic [2:0] PH_DB = 3'd3;

	logic [4:0] state_q, state_d, post;
	logic [2:0] ph_q, ph_d;
	logic       out_valid_q, free;

	assign free = !out_valid_q || out_ready;

	// state after a divide
	always_comb begin
		unique case (ph_q)
			PH_ST:   post = S_ST_CAP;
			PH_SP:   post = S_SP_CAP;
			PH_DB:   post = S_DB_CAP;
			default: post = S_IDLE;
		endcase
	end

	// next state and datapath command
	always_comb begin
		state_d       = state_q;
		ph_d          = ph_q;
		cmd.op        = OP_NONE;
		cmd.div_start = 1'b0;
		cmd.out_load  = 1'b0;
		in_ready      = state_q == S_IDLE;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.op = OP_LOAD;
				unique case (in_command)
					CMD_STEER: begin
						state_d = S_ST_PREP;
						ph_d    = PH_ST;
					end
					CMD_SPEED: begin
						state_d = S_SP_MUL1;
						ph_d    = PH_SP;
					end
					CMD_THROTTLE: state_d = S_TH_PREP;
					default: state_d = S_IDLE;
				endcase
			end
			S_ST_PREP: begin
				cmd.op  = OP_ST_PREP;
				state_d = S_DIV_GO;
			end
			S_SP_MUL1: begin
				cmd.op  = OP_SP_MUL1;
				state_d = S_SP_MUL2;
			end
			S_SP_MUL2: begin
				cmd.op  = OP_SP_MUL2;
				state_d = S_SP_CLAMP;
			end
			S_SP_CLAMP: begin
				cmd.op  = OP_SP_CLAMP;
				state_d = S_SP_SCALE;
			end
			S_SP_SCALE: begin
				cmd.op  = OP_SP_SCALE;
				state_d = S_DIV_GO;
			end
			S_TH_PREP: begin
				cmd.op  = OP_TH_PREP;
				state_d = S_FIN;
			end
			S_DIV_GO: begin
				if (stat.skip) begin
					state_d = post;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV_WAIT;
				end
			end
			S_DIV_WAIT: if (stat.div_done) state_d = post;
			S_ST_CAP: begin
				cmd.op  = OP_ST_CAP;
				state_d = S_FIN;
			end
			S_SP_CAP: begin
				cmd.op  = OP_SP_CAP;
				state_d = S_IX_PREP;
			end
			S_IX_PREP: begin
				cmd.op  = OP_IX_PREP;
				state_d = S_DB_RDL;
			end
			S_DB_RDL: begin
				cmd.op  = OP_DB_RDL;
				state_d = S_DB_RDR;
			end
			S_DB_RDR: begin
				cmd.op  = OP_DB_RDR;
				state_d = S_DB_LATR;
			end
			S_DB_LATR: begin
				cmd.op  = OP_DB_LATR;
				state_d = S_DB_PREP;
			end
			S_DB_PREP: begin
				cmd.op  = OP_DB_PREP;
				state_d = S_DB_ABS;
			end
			S_DB_ABS: begin
				cmd.op  = OP_DB_ABS;
				ph_d    = PH_DB;
				state_d = S_DIV_GO;
			end
			S_DB_CAP: begin
				cmd.op  = OP_DB_CAP;
				state_d = S_SP_PUSH;
			end
			S_SP_PUSH: begin
				cmd.op  = OP_SP_PUSH;
				state_d = S_FIN;
			end
			S_FIN: if (free) begin
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= PH_ST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`STSM_ASSERT_SAME(a_load_free, cmd.out_load, !out_valid_q || out_ready, "result beat overwritten")
	`STSM_ASSERT_NEXT(a_load_shown, cmd.out_load, out_valid_q, "loaded result beat not shown")
	`STSM_ASSERT_SAME(a_done_wait, stat.div_done, state_q == S_DIV_WAIT, "divider done out of wait")
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the steering and throttle servo mapper.
`timescale 1ns / 1ps

module testbench;
	import stsm_pkg::*;

	// index past the register list, written to check it is ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct {
		logic [1:0]         cmd;
		logic signed [15:0] val;
		logic [3:0]         idx;
		logic [14:0]        bp;
		logic [14:0]        db;
		bit                 typed;
		int                 pos;
	} cmd_row_t;

	typedef struct {
		logic       chan;
		logic [7:0] pos;
	} servo_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	stsm_in_if  cmd_if();
	stsm_out_if res_if();

	steer_throttle_servo_mapper_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_if.sink),
		.res_ch    (res_if.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// mirrored block state
	longint min_deg, max_deg, fwd_gain, rev_gain, rpm_scale, rpm_lo, rpm_hi;
	longint steer_q;
	logic [14:0] bp_tab [0:15];
	logic [14:0] db_tab [0:15];

	servo_beat_t pending_pos[$];
	int  mismatches;
	bit  no_gaps;
	bit  hold_long;

	// directed rows: reset config, then table loads and deadband cases
	localparam int N_DIR = 20;
	cmd_row_t dir_rows [0:N_DIR-1] = '{
		'{CMD_STEER,    16'sd0,      0, 0, 0, 1, 90},
		'{CMD_STEER,    16'sd32767,  0, 0, 0, 1, 180},
		'{CMD_STEER,    -16'sd32768, 0, 0, 0, 1, 0},
		'{CMD_THROTTLE, -16'sd25600, 0, 0, 0, 1, 0},
		'{CMD_THROTTLE, 16'sd25600,  0, 0, 0, 1, 180},
		'{CMD_THROTTLE, 16'sd32767,  0, 0, 0, 1, 180},
		'{CMD_THROTTLE, -16'sd32768, 0, 0, 0, 1, 0},
		'{CMD_THROTTLE, 16'sd0,      0, 0, 0, 1, 90},
		'{CMD_SPEED,    16'sd0,      0, 0, 0, 1, 90},
		'{CMD_SPEED,    16'sd32767,  0, 0, 0, 1, 180},
		'{CMD_SPEED,    -16'sd32768, 0, 0, 0, 1, 0},
		'{CMD_WRITE,    16'sd0,      0, 0, 23040, 0, 0},
		'{CMD_WRITE,    -16'sd1,     1, 1024, 0, 0, 0},
		'{CMD_WRITE,    16'sd0,      15, 32767, 23040, 0, 0},
		'{CMD_WRITE,    16'sd0,      14, 32767, 100, 0, 0},
		'{CMD_STEER,    16'sd0,      0, 0, 0, 1, 90},
		'{CMD_SPEED,    16'sd256,    0, 0, 0, 0, 0},
		'{CMD_SPEED,    -16'sd256,   0, 0, 0, 0, 0},
		'{CMD_STEER,    16'sd32767,  0, 0, 0, 0, 0},
		'{CMD_SPEED,    16'sd100,    0, 0, 0, 0, 0}
	};

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint sat_servo(input longint whole);
		if (whole < 0)
			return 0;
		if (whole > POS_MAX)
			return POS_MAX;
		return whole;
	endfunction

	function automatic void reset_mirror();
		min_deg = -30;
		max_deg = 30;
		fwd_gain = 4096;
		rev_gain = 4096;
		rpm_scale = 20352;
		rpm_lo = -1000;
		rpm_hi = 1000;
		steer_q = 0;
		for (int i = 0; i < 16; i++) begin
			bp_tab[i] = '0;
			db_tab[i] = '0;
		end
	endfunction

	function automatic void mirror_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] data);
		case (idx)
			REG_MIN_STEER: min_deg = longint'($signed(data[7:0]));
			REG_MAX_STEER: max_deg = longint'($signed(data[7:0]));
			REG_FWD_GAIN:  fwd_gain = longint'(data);
			REG_REV_GAIN:  rev_gain = longint'(data);
			REG_RPM_SPEED: rpm_scale = longint'(data);
			REG_MIN_RPM:   rpm_lo = longint'($signed(data));
			REG_MAX_RPM:   rpm_hi = longint'($signed(data));
			default: ;
		endcase
	endfunction

	// interpolated deadband half-width (Q8.8) at the stored steering angle
	function automatic longint deadband_half();
		longint ang, l, r, bl, br, dl, dr;
		ang = (steer_q < 0) ? -steer_q : steer_q;
		l = ang / (STEP_DEGREES * 256);
		if (l > 15)
			l = 15;
		r = (l + 1 >= 16) ? l : l + 1;
		bl = bp_tab[l];
		br = bp_tab[r];
		dl = db_tab[l];
		dr = db_tab[r];
		if (br == bl)
			return dl;
		return ((ang - bl) * (dr - dl)) / (br - bl) + dl;
	endfunction

	// servo position for one command; returns 0 when no beat follows
	function automatic bit servo_predict(input cmd_row_t c, output servo_beat_t b);
		longint v, lo, hi, a, p, rpm, w;
		v = longint'(c.val);
		b.chan = 1'b1;
		case (c.cmd)
			CMD_STEER: begin
				lo = min_deg * 256;
				hi = max_deg * 256;
				a = v;
				if (a < lo)
					a = lo;
				else if (a > hi)
					a = hi;
				steer_q = a;
				p = (hi != lo) ? ((a - lo) * 180) / (hi - lo) : 0;
				b.chan = 1'b0;
				b.pos = 8'(sat_servo(p));
			end
			CMD_SPEED: begin
				rpm = v * ((v < 0) ? rev_gain : fwd_gain) * rpm_scale;
				lo = rpm_lo <<< 26;
				hi = rpm_hi <<< 26;
				if (rpm < lo)
					rpm = lo;
				if (rpm > hi)
					rpm = hi;
				p = (hi != lo) ? ((rpm - lo) * FULL_Q) / (hi - lo) : 0;
				w = deadband_half();
				if (p != CENTER_Q && p > CENTER_Q - w && p < CENTER_Q + w)
					p = (p < CENTER_Q) ? CENTER_Q - w : CENTER_Q + w;
				b.pos = 8'(sat_servo(p / 256));
			end
			CMD_THROTTLE: begin
				b.pos = 8'(sat_servo(((v + THR_OFFS) * 9) / THR_DEN));
			end
			default: begin
				bp_tab[c.idx] = c.bp;
				db_tab[c.idx] = c.db;
				return 0;
			end
		endcase
		return 1;
	endfunction

	function automatic int draw_gap();
		if (no_gaps)
			return 0;
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
	endfunction

	// offer one command beat and predict its result once it is taken
	task automatic send_cmd(input cmd_row_t c);
		int gap;
		servo_beat_t b;
		gap = draw_gap();
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid          <= 1'b1;
		cmd_if.command        <= c.cmd;
		cmd_if.value          <= c.val;
		cmd_if.table_index    <= c.idx;
		cmd_if.table_steer    <= c.bp;
		cmd_if.table_deadband <= c.db;
		do @(posedge clk); while (!cmd_if.ready);
		if (servo_predict(c, b)) begin
			if (c.typed)
				b.pos = 8'(c.pos);
			pending_pos.push_back(b);
		end
	endtask

	// let every expected beat arrive, then the block settle
	task automatic drain();
		cmd_if.valid <= 1'b0;
		while (pending_pos.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		mirror_reg(idx, data);
	endtask

	task automatic load_regs(input logic [CFG_W-1:0] r0, input logic [CFG_W-1:0] r1,
		input logic [CFG_W-1:0] r2, input logic [CFG_W-1:0] r3, input logic [CFG_W-1:0] r4,
		input logic [CFG_W-1:0] r5, input logic [CFG_W-1:0] r6);
		write_reg(REG_MIN_STEER, r0);
		write_reg(REG_MAX_STEER, r1);
		write_reg(REG_FWD_GAIN, r2);
		write_reg(REG_REV_GAIN, r3);
		write_reg(REG_RPM_SPEED, r4);
		write_reg(REG_MIN_RPM, r5);
		write_reg(REG_MAX_RPM, r6);
		// unused index, must be ignored
		write_reg(REG_SPARE, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// random command: mostly well-formed tables and moderate values
	function automatic cmd_row_t rand_cmd();
		cmd_row_t c;
		c.typed = 0;
		c.pos   = 0;
		c.cmd   = 2'($urandom_range(0, 3));
		c.idx   = 4'($urandom);
		c.bp    = 15'($urandom);
		c.db    = 15'($urandom);
		c.val   = 16'($urandom);
		if (c.cmd == CMD_WRITE && $urandom_range(0, 4) != 0) begin
			c.bp = 15'(c.idx * STEP_DEGREES * 256 + $urandom_range(0, 255));
			c.db = 15'($urandom_range(0, 23040));
		end
		if (c.cmd != CMD_WRITE && $urandom_range(0, 1) == 0)
			c.val = 16'(int'($urandom_range(0, 2 * 25600)) - 25600);
		return c;
	endfunction

	task automatic random_cmds(input int n);
		for (int i = 0; i < n; i++)
			send_cmd(rand_cmd());
	endtask

	// result side: random stalls, compare each beat with the oldest prediction
	initial begin
		int stall;
		servo_beat_t exp_b;
		res_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (hold_long) begin
				hold_long = 0;
				stall = 400;
			end
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			if (pending_pos.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: chan %0d pos %0d",
						res_if.servo_channel, res_if.servo_position);
			end else begin
				exp_b = pending_pos.pop_front();
				if (res_if.servo_channel !== exp_b.chan ||
					res_if.servo_position !== exp_b.pos) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat mismatch: exp chan %0d pos %0d, got chan %0d pos %0d",
							exp_b.chan, exp_b.pos, res_if.servo_channel,
							res_if.servo_position);
				end
			end
		end
	end

	// main sequence
	initial begin
		cmd_row_t tbl_row;
		mismatches = 0;
		no_gaps = 0;
		hold_long = 0;
		reset_mirror();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cmd_if.valid <= 1'b0;
		cmd_if.command <= CMD_STEER;
		cmd_if.value <= '0;
		cmd_if.table_index <= '0;
		cmd_if.table_steer <= '0;
		cmd_if.table_deadband <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_cmd(dir_rows[i]);
		random_cmds(100);
		drain();

		// extremes, back to back on both sides
		load_regs(16'hFFA6, 16'h005A, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
		no_gaps = 1;
		random_cmds(130);
		no_gaps = 0;
		drain();

		// equal limits everywhere, zero gains
		load_regs(16'h000A, 16'h000A, 16'h0000, 16'h0000, 16'h0000, 16'h01F4, 16'h01F4);
		random_cmds(120);
		drain();

		// inverted limits
		load_regs(16'h0028, 16'hFFD8, 16'd4096, 16'd8192, 16'd20352, 16'd1000, 16'hFC18);
		random_cmds(120);
		drain();

		// arbitrary register contents
		load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom));
		random_cmds(120);
		drain();

		// wide steering range with a clean ascending table; long output stall
		load_regs(16'hFFA6, 16'h005A, 16'd4096, 16'd4096, 16'd20352, 16'hF830, 16'd2000);
		for (int i = 0; i < 16; i++) begin
			tbl_row = '{CMD_WRITE, 16'sd0, 4'(i), 15'(i * STEP_DEGREES * 256),
				15'($urandom_range(0, 23040)), 0, 0};
			send_cmd(tbl_row);
		end
		hold_long = 1;
		random_cmds(140);
		drain();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// run limit
	initial begin
		#8ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- steer_throttle_servo_mapper_unit.f -----
+incdir+rtl
rtl/stsm_pkg.sv
rtl/stsm_if.sv
rtl/stsm_div.sv
rtl/stsm_datapath.sv
rtl/stsm_ctrl.sv
rtl/steer_throttle_servo_mapper_unit.sv
tb/testbench.sv
